// ===== hw/rtl/utxq_pkg.sv =====
// Shared types and codes for the UART transmit message slot queue.
`default_nettype none

package utxq_pkg;

  typedef enum logic [1:0] {
    CMD_PUSH   = 2'd0,
    CMD_FINISH = 2'd1,
    CMD_ENABLE = 2'd2,
    CMD_READ   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_DONE    = 2'd0,
    STAT_DROP    = 2'd1,
    STAT_IGNORED = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_EXEC = 2'd1,
    S_READ = 2'd2,
    S_WALK = 2'd3
  } state_t;

  typedef logic [1:0] port_fld_t;
  typedef logic [7:0] byte_fld_t;
  typedef logic [2:0] slot_fld_t;
  typedef logic [6:0] off_fld_t;
  typedef logic [7:0] len_fld_t;

endpackage

`default_nettype wire

// ===== hw/rtl/utxq_ram.sv =====
// Simple dual-port RAM with one write port and one registered read port.
`default_nettype none

module utxq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/uart_tx_message_slot_queue.sv =====
// Top level of the shared UART transmit queue of message slots.
// A request is taken when in_valid is high and in_stall is low, and each request gives
// exactly one result on the output channel. A push, an enable change or an ignored
// request passes the request registers and S_EXEC into the output register, and no new
// request is taken before its result is valid. A byte readback also passes S_READ since
// the slot store has a registered read port. A send-finished request retires the sending
// slot and steps on, retiring and skipping closed slots of disabled ports, until one is
// started or the next slot is open. That walk uses a single slot step unit and reads the
// slot length and port table one entry per cycle. The next request is taken in the same
// cycle that the previous result is taken, and a stalled result holds off input.
`default_nettype none

module uart_tx_message_slot_queue #(
  parameter int SLOTS      = 8,
  parameter int SLOT_BYTES = 128,
  parameter int PORTS      = 3
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [1:0] cmd,
  input  wire logic [1:0] port,
  input  wire logic [7:0] data_byte,
  input  wire logic       last_byte,
  input  wire logic       enable_flag,
  input  wire logic [2:0] read_slot,
  input  wire logic [6:0] read_offset,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [1:0]      status,
  output logic            start_valid,
  output logic [2:0]      start_slot,
  output logic [7:0]      start_len,
  output logic [1:0]      start_port,
  output logic [7:0]      read_data,
  output logic            ring_full
);

  localparam int SW = $clog2(SLOTS);
  localparam int LW = $clog2(SLOT_BYTES + 1);
  localparam int AW = $clog2(SLOTS * SLOT_BYTES);
  localparam int MW = LW + 2;

  utxq_pkg::state_t    state, state_next;
  utxq_pkg::cmd_t      q_cmd;
  utxq_pkg::port_fld_t q_port;
  utxq_pkg::byte_fld_t q_byte;
  logic                q_last;
  logic                q_en;
  utxq_pkg::slot_fld_t q_rslot;
  utxq_pkg::off_fld_t  q_roff;

  logic [SLOTS-1:0] closed, closed_next;
  logic [SW-1:0]    free_index, free_index_next;
  logic             full_flag, full_next;
  logic [SW-1:0]    sending_index, sending_next;
  logic             sender_idle, idle_next;
  logic [LW-1:0]    fill_count, fill_next;
  logic             dropping, dropping_next;
  logic [PORTS-1:0] port_enables, pe_next;

  logic             in_accept;
  logic             out_load;
  logic             out_valid_next;
  logic [1:0]       status_next;
  logic             start_valid_next;
  logic [2:0]       start_slot_next;
  logic [7:0]       start_len_next;
  logic [1:0]       start_port_next;
  logic [7:0]       read_data_next;

  logic             port_ok;
  logic             read_ok;
  logic [LW-1:0]    fill_new;
  logic [SW-1:0]    free_succ;
  logic [SW-1:0]    walk_nx;
  logic             walk_go;
  logic [PORTS-1:0] pe_mask;
  logic [PORTS-1:0] pe_shift;

  logic             st_we, st_re;
  logic [AW-1:0]    st_waddr, st_raddr;
  logic [7:0]       st_rdata;
  logic             md_we, md_re;
  logic [MW-1:0]    md_wdata, md_rdata;
  logic [LW-1:0]    md_len;
  logic [1:0]       md_port;

  assign in_stall  = (state != utxq_pkg::S_IDLE) || (out_valid && out_stall);
  assign in_accept = in_valid && !in_stall;

  assign port_ok   = 32'(q_port) < 32'(PORTS);
  assign read_ok   = (32'(q_rslot) < 32'(SLOTS)) && (32'(q_roff) < 32'(SLOT_BYTES));
  assign fill_new  = fill_count + LW'(1);
  assign free_succ = (free_index == SW'(SLOTS - 1)) ? '0 : free_index + SW'(1);
  assign walk_nx   = (sending_index == SW'(SLOTS - 1)) ? '0 : sending_index + SW'(1);
  assign pe_mask   = PORTS'(1) << q_port;
  assign md_len    = md_rdata[MW-1:2];
  assign md_port   = md_rdata[1:0];
  assign pe_shift  = port_enables >> md_port;

  assign st_waddr = AW'(32'(free_index) * SLOT_BYTES + 32'(fill_count));
  assign st_raddr = AW'(32'(q_rslot) * SLOT_BYTES + 32'(q_roff));
  assign md_wdata = {fill_new, q_port};

  utxq_ram #(
    .WIDTH(8),
    .DEPTH(SLOTS * SLOT_BYTES)
  ) u_store (
    .clk     (clk),
    .wr_en   (st_we),
    .wr_addr (st_waddr),
    .wr_data (q_byte),
    .rd_en   (st_re),
    .rd_addr (st_raddr),
    .rd_data (st_rdata)
  );

  utxq_ram #(
    .WIDTH(MW),
    .DEPTH(SLOTS)
  ) u_meta (
    .clk     (clk),
    .wr_en   (md_we),
    .wr_addr (free_index),
    .wr_data (md_wdata),
    .rd_en   (md_re),
    .rd_addr (walk_nx),
    .rd_data (md_rdata)
  );

  always_comb begin
    state_next       = state;
    closed_next      = closed;
    free_index_next  = free_index;
    full_next        = full_flag;
    sending_next     = sending_index;
    idle_next        = sender_idle;
    fill_next        = fill_count;
    dropping_next    = dropping;
    pe_next          = port_enables;
    out_load         = 1'b0;
    status_next      = utxq_pkg::STAT_DONE;
    start_valid_next = 1'b0;
    start_slot_next  = '0;
    start_len_next   = '0;
    start_port_next  = '0;
    read_data_next   = '0;
    st_we            = 1'b0;
    st_re            = 1'b0;
    md_we            = 1'b0;
    md_re            = 1'b0;
    walk_go          = 1'b0;

    unique case (state)
      utxq_pkg::S_IDLE: begin
        if (in_accept) begin
          state_next = utxq_pkg::S_EXEC;
        end
      end
      utxq_pkg::S_EXEC: begin
        unique case (q_cmd)
          utxq_pkg::CMD_PUSH: begin
            out_load   = 1'b1;
            state_next = utxq_pkg::S_IDLE;
            priority if (!port_ok) begin
              status_next = utxq_pkg::STAT_IGNORED;
            end else if (dropping) begin
              status_next = utxq_pkg::STAT_DROP;
              if (q_last) begin
                dropping_next = 1'b0;
              end
            end else if (fill_count == '0 && full_flag) begin
              status_next = utxq_pkg::STAT_DROP;
              if (!q_last) begin
                dropping_next = 1'b1;
              end
            end else begin
              st_we = 1'b1;
              if (q_last || fill_new == LW'(SLOT_BYTES)) begin
                md_we                   = 1'b1;
                closed_next[free_index] = 1'b1;
                fill_next               = '0;
                free_index_next         = free_succ;
                if (!sender_idle && free_succ == sending_index) begin
                  full_next = 1'b1;
                end
                if (sender_idle) begin
                  sending_next     = free_index;
                  idle_next        = 1'b0;
                  start_valid_next = 1'b1;
                  start_slot_next  = utxq_pkg::slot_fld_t'(free_index);
                  start_len_next   = utxq_pkg::len_fld_t'(fill_new);
                  start_port_next  = q_port;
                end
              end else begin
                fill_next = fill_new;
              end
            end
          end
          utxq_pkg::CMD_FINISH: begin
            if (sender_idle) begin
              out_load    = 1'b1;
              status_next = utxq_pkg::STAT_IGNORED;
              state_next  = utxq_pkg::S_IDLE;
            end else begin
              walk_go = 1'b1;
            end
          end
          utxq_pkg::CMD_ENABLE: begin
            out_load   = 1'b1;
            state_next = utxq_pkg::S_IDLE;
            if (!port_ok) begin
              status_next = utxq_pkg::STAT_IGNORED;
            end else if (q_en) begin
              pe_next = port_enables | pe_mask;
            end else begin
              pe_next = port_enables & ~pe_mask;
            end
          end
          utxq_pkg::CMD_READ: begin
            if (!read_ok) begin
              out_load    = 1'b1;
              status_next = utxq_pkg::STAT_IGNORED;
              state_next  = utxq_pkg::S_IDLE;
            end else begin
              st_re      = 1'b1;
              state_next = utxq_pkg::S_READ;
            end
          end
          default: begin
            state_next = utxq_pkg::S_IDLE;
          end
        endcase
      end
      utxq_pkg::S_READ: begin
        out_load       = 1'b1;
        read_data_next = st_rdata;
        state_next     = utxq_pkg::S_IDLE;
      end
      utxq_pkg::S_WALK: begin
        if (pe_shift[0]) begin
          out_load         = 1'b1;
          start_valid_next = 1'b1;
          start_slot_next  = utxq_pkg::slot_fld_t'(sending_index);
          start_len_next   = utxq_pkg::len_fld_t'(md_len);
          start_port_next  = md_port;
          state_next       = utxq_pkg::S_IDLE;
        end else begin
          walk_go = 1'b1;
        end
      end
      default: begin
        state_next = utxq_pkg::S_IDLE;
      end
    endcase

    // One step of the send-finished walk: retire the sending slot and look at the next.
    if (walk_go) begin
      closed_next[sending_index] = 1'b0;
      if (full_flag) begin
        free_index_next = sending_index;
        full_next       = 1'b0;
      end
      sending_next = walk_nx;
      if (closed[walk_nx]) begin
        md_re      = 1'b1;
        state_next = utxq_pkg::S_WALK;
      end else begin
        idle_next  = 1'b1;
        out_load   = 1'b1;
        state_next = utxq_pkg::S_IDLE;
      end
    end
  end

  always_comb begin
    if (out_load) begin
      out_valid_next = 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= utxq_pkg::S_IDLE;
      out_valid     <= 1'b0;
      closed        <= '0;
      free_index    <= '0;
      full_flag     <= 1'b0;
      sending_index <= '0;
      sender_idle   <= 1'b1;
      fill_count    <= '0;
      dropping      <= 1'b0;
      port_enables  <= '0;
    end else begin
      state         <= state_next;
      out_valid     <= out_valid_next;
      closed        <= closed_next;
      free_index    <= free_index_next;
      full_flag     <= full_next;
      sending_index <= sending_next;
      sender_idle   <= idle_next;
      fill_count    <= fill_next;
      dropping      <= dropping_next;
      port_enables  <= pe_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      q_cmd   <= utxq_pkg::cmd_t'(cmd);
      q_port  <= port;
      q_byte  <= data_byte;
      q_last  <= last_byte;
      q_en    <= enable_flag;
      q_rslot <= read_slot;
      q_roff  <= read_offset;
    end
    if (out_load) begin
      status      <= status_next;
      start_valid <= start_valid_next;
      start_slot  <= start_slot_next;
      start_len   <= start_len_next;
      start_port  <= start_port_next;
      read_data   <= read_data_next;
      ring_full   <= full_next;
    end
  end

  a_full_means_sending: assert property (@(posedge clk) disable iff (rst)
    full_flag |-> !sender_idle)
    else $error("Ring is marked full while the sender is idle.");

  a_sending_slot_closed: assert property (@(posedge clk) disable iff (rst)
    !sender_idle |-> closed[sending_index])
    else $error("The slot being sent is not a closed slot.");

  a_drop_at_slot_start: assert property (@(posedge clk) disable iff (rst)
    dropping |-> (fill_count == '0))
    else $error("A message is being dropped while a slot is partly filled.");

  a_fill_in_range: assert property (@(posedge clk) disable iff (rst)
    32'(fill_count) < 32'(SLOT_BYTES))
    else $error("Fill count reached the slot size without closing the slot.");

  a_result_on_finish: assert property (@(posedge clk) disable iff (rst)
    (state != utxq_pkg::S_IDLE && state_next == utxq_pkg::S_IDLE) |=> out_valid)
    else $error("A request finished without producing a result.");

endmodule

`default_nettype wire
